// ===== src/deauth_frame_counter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Deauth frame counter assertion macros
// Shared property wrappers for the concurrent checks in the counter RTL.
// ----------------------------------------------------------------------------
`ifndef DEAUTH_FRAME_COUNTER_TOP_MACROS_SVH
`define DEAUTH_FRAME_COUNTER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define DFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DFC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Deauth frame counter package
// Shared constants, command codes and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

   // Table depth default
   localparam int TABLE_ENTRIES = 16;

   // Field widths
   localparam int MAC_W     = 48;
   localparam int FC_W      = 16;
   localparam int CHAN_W    = 4;
   localparam int RSSI_W    = 8;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 16;

   // Threshold after reset
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd10;

   // Command codes
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Frame control codes
   localparam logic [1:0] FC_TYPE_MGMT      = 2'b00;
   localparam logic [3:0] FC_SUBTYPE_DEAUTH = 4'hC;

   // Input transaction
   typedef struct packed {
      logic                     cmd;
      logic                     is_management;
      logic [FC_W-1:0]          fc_word;
      logic [MAC_W-1:0]         sender_mac;
      logic [MAC_W-1:0]         bssid;
      logic [CHAN_W-1:0]        channel;
      logic signed [RSSI_W-1:0] rssi;
      logic [TIME_W-1:0]        timestamp;
   } dfc_req_type;

   // Result transaction
   typedef struct packed {
      logic [MAC_W-1:0]         event_bssid;
      logic [MAC_W-1:0]         event_sender_mac;
      logic [CHAN_W-1:0]        event_channel;
      logic signed [RSSI_W-1:0] event_rssi;
      logic [TIME_W-1:0]        event_time;
      logic [COUNT_W-1:0]       event_count;
      logic                     table_overflow;
   } dfc_rsp_type;

   // Operation handed to the table for the transaction in flight
   typedef struct packed {
      logic clear;
      logic deauth;
   } dfc_tbl_ctrl_type;

   // Table decision for that transaction
   typedef struct packed {
      logic               emit;
      logic               overflow;
      logic [COUNT_W-1:0] count;
   } dfc_lookup_type;

endpackage

`default_nettype wire

// ===== src/dfc_ifs.sv =====
// ----------------------------------------------------------------------------
// Deauth frame counter channel interfaces
// Valid/ready channels for frame requests and event responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfc_req_if;
   logic                 valid;
   logic                 ready;
   dfc_pkg::dfc_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dfc_rsp_if;
   logic                 valid;
   logic                 ready;
   dfc_pkg::dfc_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/dfc_table.sv =====
// ----------------------------------------------------------------------------
// Deauth frame counter BSSID table
// Associative per-BSSID counters with parallel match and same-cycle update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deauth_frame_counter_top_macros.svh"

module dfc_table #(
   parameter int TableEntries = dfc_pkg::TABLE_ENTRIES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dfc_pkg::dfc_tbl_ctrl_type     ctrl,
   input  wire logic [dfc_pkg::MAC_W-1:0]     bssid,
   input  wire logic [dfc_pkg::COUNT_W-1:0]   threshold,
   output      dfc_pkg::dfc_lookup_type       lookup
);

   logic [TableEntries-1:0]           valid_ff;
   logic [dfc_pkg::MAC_W-1:0]         bssid_ff [TableEntries];
   logic [dfc_pkg::COUNT_W-1:0]       count_ff [TableEntries];

   logic [TableEntries-1:0]           match;
   logic [TableEntries-1:0]           free_vec;
   logic [TableEntries-1:0]           alloc;
   logic                              hit;
   logic                              under;
   logic                              thr_nonzero;
   logic                              do_incr;
   logic                              do_alloc;
   logic [dfc_pkg::COUNT_W-1:0]       hit_count;

   // Compare every valid entry against the incoming BSSID
   always_comb begin
      for (int i = 0; i < TableEntries; i++) begin
         match[i]    = valid_ff[i] && (bssid_ff[i] == bssid);
         free_vec[i] = !valid_ff[i];
      end
   end

   // Isolate the lowest free entry
   assign alloc = free_vec & (~free_vec + TableEntries'(1));

   // Select the count of the matching entry (at most one matches)
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < TableEntries; i++) begin
         hit_count = hit_count | (match[i] ? count_ff[i] : '0);
      end
   end

   assign hit         = |match;
   assign under       = hit_count < threshold;
   assign thr_nonzero = threshold != '0;
   assign do_incr     = ctrl.deauth && hit && under;
   assign do_alloc    = ctrl.deauth && !hit && thr_nonzero;

   // Decide the event for this transaction
   always_comb begin
      lookup.emit     = ctrl.deauth && (hit ? under : thr_nonzero);
      lookup.overflow = do_alloc && (free_vec == '0);
      lookup.count    = '0;
      if (hit) begin
         lookup.count = hit_count + dfc_pkg::COUNT_W'(1);
      end else if (free_vec != '0) begin
         lookup.count = dfc_pkg::COUNT_W'(1);
      end
   end

   // Update valid bits and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < TableEntries; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ctrl.clear) begin
         valid_ff <= '0;
         for (int i = 0; i < TableEntries; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TableEntries; i++) begin
            if (do_incr && match[i]) begin
               count_ff[i] <= count_ff[i] + dfc_pkg::COUNT_W'(1);
            end else if (do_alloc && alloc[i]) begin
               valid_ff[i] <= 1'b1;
               count_ff[i] <= dfc_pkg::COUNT_W'(1);
            end
         end
      end
   end

   // Store the BSSID of a newly taken entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < TableEntries; i++) begin
         if (do_alloc && alloc[i] && !ctrl.clear) begin
            bssid_ff[i] <= bssid;
         end
      end
   end

   `DFC_ASSERT(a_match_unique, $onehot0(match), "BSSID matches more than one entry")
   `DFC_ASSERT(a_overflow_full, lookup.overflow |-> (&valid_ff), "overflow with a free entry")
   `DFC_ASSERT(a_clear_empties, ctrl.clear |=> (valid_ff == '0), "clear left valid entries")

endmodule

`default_nettype wire

// ===== src/deauth_frame_counter_top.sv =====
// ----------------------------------------------------------------------------
// Deauth frame counter top level
// Counts deauthentication frames per BSSID and emits events up to a count threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per captured frame header, or a clear
//   command (cmd = 1) that empties the BSSID table. rsp_if carries at most
//   one event per request: a deauth frame whose BSSID count is still below
//   the count threshold, or one that found the table full (table_overflow = 1,
//   event_count = 0). Other requests produce no event.
//   csr_wr_en / csr_wr_data write the count threshold; write it only while idle.
//   Path: an accepted request is held in the input register, and its outcome
//   is registered in the result register, from which the event is taken.
//   Throughput: one request per cycle while no held event blocks it; the input
//   register feeds a parallel table match and update into the result register.
//   Reset: the table is empty and the count threshold returns to 10.
//   Stall: while rsp_if.ready is low a held event blocks the request in the
//   input register, and req_if.ready drops once that register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module deauth_frame_counter_top #(
   parameter int TableEntries = dfc_pkg::TABLE_ENTRIES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [dfc_pkg::COUNT_W-1:0] csr_wr_data,
   dfc_req_if.sink                          req_if,
   dfc_rsp_if.source                        rsp_if
);

   logic [dfc_pkg::COUNT_W-1:0] thr_ff;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   dfc_pkg::dfc_req_type        s1_data_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   dfc_pkg::dfc_rsp_type        rsp_data_ff;
   logic                        req_accept;
   logic                        proc;
   logic                        is_deauth;
   dfc_pkg::dfc_tbl_ctrl_type   tbl_ctrl;
   dfc_pkg::dfc_lookup_type     lookup;

   // Hold the threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= dfc_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Advance the input register when the result slot can take its outcome
   assign proc          = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || proc;
   assign req_accept    = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_if.payload;
      end
   end

   // Classify the held transaction
   assign is_deauth = (s1_data_ff.cmd == dfc_pkg::CMD_FRAME)
                   && s1_data_ff.is_management
                   && (s1_data_ff.fc_word[3:2] == dfc_pkg::FC_TYPE_MGMT)
                   && (s1_data_ff.fc_word[7:4] == dfc_pkg::FC_SUBTYPE_DEAUTH);

   assign tbl_ctrl.clear  = proc && (s1_data_ff.cmd == dfc_pkg::CMD_CLEAR);
   assign tbl_ctrl.deauth = proc && is_deauth;

   dfc_table #(
      .TableEntries (TableEntries)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tbl_ctrl),
      .bssid     (s1_data_ff.bssid),
      .threshold (thr_ff),
      .lookup    (lookup)
   );

   // Load or drop the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = lookup.emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && lookup.emit) begin
         rsp_data_ff.event_bssid      <= s1_data_ff.bssid;
         rsp_data_ff.event_sender_mac <= s1_data_ff.sender_mac;
         rsp_data_ff.event_channel    <= s1_data_ff.channel;
         rsp_data_ff.event_rssi       <= s1_data_ff.rssi;
         rsp_data_ff.event_time       <= s1_data_ff.timestamp;
         rsp_data_ff.event_count      <= lookup.overflow ? '0 : lookup.count;
         rsp_data_ff.table_overflow   <= lookup.overflow;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

`default_nettype wire
